>>> rtl/nwhc_pkg.sv
`timescale 1ns / 1ps

package nwhc_pkg;

  localparam int PosW    = 24;
  localparam int QuatW   = 16;
  localparam int GainW   = 12;
  localparam int SpeedW  = 12;
  localparam int AngOutW = 16;
  localparam int IdxOutW = 10;
  localparam int TurnW   = 32;
  // CORDIC datapath: operands are normalised into [2^40, 2^41) before the first step
  localparam int CordW   = 44;
  localparam int NormBit = 40;
  localparam int TurnSteps = 24;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpClear  = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  localparam logic CfgTurnGain = 1'b0;
  localparam logic CfgFwdSpeed = 1'b1;

  // 2*pi*1000 in Q16
  localparam logic signed [29:0] MradQ16 = 30'sd411774832;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TurnW-1:0] TurnTable [TurnSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic        [TurnW-1:0] z;
  } cordic_t;

endpackage

>>> rtl/nwhc_cordic_cell.sv
`timescale 1ns / 1ps

module nwhc_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              v_i,
  input  nwhc_pkg::cordic_t c_i,
  output logic              v_o,
  output nwhc_pkg::cordic_t c_o
);
  import nwhc_pkg::*;

  localparam logic [TurnW-1:0] Angle = TurnTable[STEP];

  logic signed [CordW-1:0] xs, ys;
  cordic_t c_d, c_q;
  logic    v_q;

  // rotate towards y = 0
  always_comb begin
    xs = c_i.x >>> STEP;
    ys = c_i.y >>> STEP;
    if (!c_i.y[CordW-1]) begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + Angle;
    end else begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign v_o = v_q;
  assign c_o = c_q;

endmodule

>>> rtl/nwhc_atan.sv
`timescale 1ns / 1ps

module nwhc_atan #(
  parameter int unsigned ITERS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [nwhc_pkg::CordW-1:0]  y_i,
  input  logic signed [nwhc_pkg::CordW-1:0]  x_i,
  output logic                               done_o,
  output logic        [nwhc_pkg::TurnW-1:0]  turn_o
);
  import nwhc_pkg::*;

  logic                    norm_q;
  logic                    done_q;
  logic [TurnW-1:0]        turn_q;
  logic signed [CordW-1:0] x_q, y_q;
  logic [TurnW-1:0]        z_q;
  logic [CordW-1:0]        ymag;
  logic                    big;

  cordic_t          chain_c [ITERS+1];
  logic [ITERS:0]   chain_v;

  // x is already non-negative here; only y needs its magnitude
  assign ymag = y_q[CordW-1] ? CordW'(-y_q) : CordW'(y_q);
  assign big  = (x_q[CordW-1:NormBit] != '0) || (ymag[CordW-1:NormBit] != '0);

  assign chain_v[0]   = norm_q && big;
  assign chain_c[0].x = x_q;
  assign chain_c[0].y = y_q;
  assign chain_c[0].z = z_q;

  for (genvar k = 0; k < ITERS; k++) begin : g_cell
    nwhc_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .v_i   (chain_v[k]),
      .c_i   (chain_c[k]),
      .v_o   (chain_v[k+1]),
      .c_o   (chain_c[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= chain_v[ITERS] || (start_i && x_i == '0 && y_i == '0);
      if (start_i) begin
        norm_q <= !(x_i == '0 && y_i == '0);
      end else if (norm_q && big) begin
        norm_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // left half-plane: rotate by half a turn first
      if (x_i[CordW-1]) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= 32'h80000000;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (norm_q && !big) begin
      x_q <= x_q <<< 1;
      y_q <= y_q <<< 1;
    end
    if (start_i) begin
      turn_q <= '0;
    end else if (chain_v[ITERS]) begin
      turn_q <= chain_c[ITERS].z;
    end
  end

  assign done_o = done_q;
  assign turn_o = turn_q;

endmodule

>>> rtl/nearest_waypoint_heading_controller.sv
`timescale 1ns / 1ps

// Nearest-waypoint heading controller. Op 0 appends a waypoint (ignored when the plan
// is full), op 1 clears the plan, op 2 queries a pose and yields one result transfer;
// op 3 is dropped. For a query the waypoint memory is scanned one entry a cycle
// through a four-deep distance pipeline, then the shared CORDIC unit (a chain of
// CORDIC_ITERATIONS cells, fed after a one-bit-a-cycle normalisation) runs twice,
// once for the bearing and once for the yaw. An empty plan answers with plan_empty
// set and zeros elsewhere. Input is taken only when the sequencer is idle; a
// finished result is held in an output register, so appends and clears proceed
// while it waits to be taken. Configuration writes take effect at once and belong
// to quiet periods only.
module nearest_waypoint_heading_controller #(
  parameter int unsigned MAX_WAYPOINTS     = 1024,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration
  input  logic                                     cfg_we_i,
  input  logic                                     cfg_idx_i,
  input  logic        [nwhc_pkg::GainW-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic        [1:0]                        op_i,
  input  logic signed [nwhc_pkg::PosW-1:0]         pos_x_i,
  input  logic signed [nwhc_pkg::PosW-1:0]         pos_y_i,
  input  logic signed [nwhc_pkg::QuatW-1:0]        quat_x_i,
  input  logic signed [nwhc_pkg::QuatW-1:0]        quat_y_i,
  input  logic signed [nwhc_pkg::QuatW-1:0]        quat_z_i,
  input  logic signed [nwhc_pkg::QuatW-1:0]        quat_w_i,
  // result channel
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [nwhc_pkg::SpeedW-1:0]       linear_speed_o,
  output logic signed [nwhc_pkg::AngOutW-1:0]      angular_speed_o,
  output logic                                     plan_empty_o,
  output logic        [nwhc_pkg::IdxOutW-1:0]      nearest_index_o
);
  import nwhc_pkg::*;

  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int DW = PosW + 1;        // coordinate difference
  localparam int SW = 2 * DW - 1;      // one square, non-negative
  localparam int QW = 2 * QuatW;       // one quaternion product

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_BSTART = 4'd2;
  localparam logic [3:0] S_BWAIT  = 4'd3;
  localparam logic [3:0] S_Y1     = 4'd4;
  localparam logic [3:0] S_Y2     = 4'd5;
  localparam logic [3:0] S_Y3     = 4'd6;
  localparam logic [3:0] S_YSTART = 4'd7;
  localparam logic [3:0] S_YWAIT  = 4'd8;
  localparam logic [3:0] S_E1     = 4'd9;
  localparam logic [3:0] S_E2     = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // yaw cases
  localparam logic [1:0] YawNormal  = 2'd0;
  localparam logic [1:0] YawFlipNeg = 2'd1;
  localparam logic [1:0] YawFlipPos = 2'd2;

  logic [3:0] state_q, state_d;

  // registers
  logic        [GainW-1:0]  gain_q;
  logic signed [SpeedW-1:0] speed_q;

  // plan store
  logic [2*PosW-1:0] wp_mem [MAX_WAYPOINTS];
  logic [CW-1:0]     count_q;
  logic              in_xfer;

  // latched query
  logic signed [PosW-1:0]  px_q, py_q;
  logic signed [QuatW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic                    empty_q;

  // scan pipeline
  logic [CW-1:0]          iss_q;
  logic [2*PosW-1:0]      rd_q;
  logic [AW-1:0]          idx1_q, idx2_q, idx3_q;
  logic                   v1_q, v2_q, v3_q;
  logic signed [DW-1:0]   ax2_q, ay2_q, ax3_q, ay3_q;
  logic [SW-1:0]          sqx_q, sqy_q;
  logic signed [2*DW-1:0] sqx_full, sqy_full;
  logic [SW:0]            sq_dist;
  logic [SW:0]            best_d_q;
  logic [AW-1:0]          best_i_q;
  logic signed [DW-1:0]   best_dx_q, best_dy_q;
  logic                   scan_done;

  // yaw arithmetic
  logic signed [QW-1:0]   pxx_q, pyy_q, pzz_q, pww_q, pxz_q, pwy_q, pxy_q, pwz_q;
  logic signed [QW+1:0]   n_q, ya_q;
  logic signed [QW:0]     t_q, yb_q;
  logic signed [52:0]     t_pos, t_neg, n_k;
  logic [1:0]             mode_q;

  // shared CORDIC
  logic                    at_start, at_done;
  logic signed [CordW-1:0] at_x, at_y;
  logic [TurnW-1:0]        at_turn;
  logic [TurnW-1:0]        bear_q, yaw_q, yaw_d;

  // error and gain
  logic [TurnW-1:0]        err_rnd;
  logic signed [AngOutW-1:0] e_val;
  logic signed [28:0]      p1_q;
  logic signed [57:0]      p2_q;
  logic [57:0]             p_mag, p_rnd;
  logic [17:0]             pm;
  logic signed [AngOutW-1:0] ang_d;

  // output register
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] lin_q;
  logic signed [AngOutW-1:0] ang_q;
  logic                     empty_o_q;
  logic [IdxOutW-1:0]       nidx_q;
  logic                     out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainW'(384);
      speed_q <= SpeedW'(200);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTurnGain: gain_q  <= cfg_wdata_i;
        CfgFwdSpeed: speed_q <= $signed(cfg_wdata_i[SpeedW-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- plan store
  always_ff @(posedge clk_i) begin
    if (in_xfer && op_i == OpAppend && count_q < CW'(MAX_WAYPOINTS)) begin
      wp_mem[count_q[AW-1:0]] <= {pos_x_i, pos_y_i};
    end
    rd_q <= wp_mem[iss_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_xfer) begin
      case (op_i)
        OpAppend: if (count_q < CW'(MAX_WAYPOINTS)) count_q <= count_q + 1'b1;
        OpClear:  count_q <= '0;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- query latch
  always_ff @(posedge clk_i) begin
    if (in_xfer && op_i == OpQuery) begin
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      qx_q    <= quat_x_i;
      qy_q    <= quat_y_i;
      qz_q    <= quat_z_i;
      qw_q    <= quat_w_i;
      empty_q <= (count_q == '0);
    end
  end

  // ---------------------------------------------------------------- distance scan
  // read -> difference -> squares -> compare; first minimum wins on ties
  assign sqx_full = ax2_q * ax2_q;
  assign sqy_full = ay2_q * ay2_q;
  assign sq_dist  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign scan_done = (iss_q == count_q) && !v1_q && !v2_q && !v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      v1_q <= 1'b0;
      if (in_xfer) begin
        iss_q <= '0;
      end else if (state_q == S_SCAN && iss_q != count_q) begin
        iss_q <= iss_q + 1'b1;
        v1_q  <= 1'b1;
      end
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= iss_q[AW-1:0];
    ax2_q  <= DW'($signed(rd_q[2*PosW-1:PosW])) - DW'(px_q);
    ay2_q  <= DW'($signed(rd_q[PosW-1:0])) - DW'(py_q);
    idx2_q <= idx1_q;
    sqx_q  <= sqx_full[SW-1:0];
    sqy_q  <= sqy_full[SW-1:0];
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
    idx3_q <= idx2_q;
    if (v3_q && (idx3_q == '0 || sq_dist < best_d_q)) begin
      best_d_q  <= sq_dist;
      best_i_q  <= idx3_q;
      best_dx_q <= ax3_q;
      best_dy_q <= ay3_q;
    end
  end

  // ---------------------------------------------------------------- yaw terms
  assign t_pos = 53'(t_q) * 53'sd200000;
  assign t_neg = -t_pos;
  assign n_k   = 53'(n_q) * 53'sd99999;

  always_ff @(posedge clk_i) begin
    if (state_q == S_Y1) begin
      pxx_q <= qx_q * qx_q;
      pyy_q <= qy_q * qy_q;
      pzz_q <= qz_q * qz_q;
      pww_q <= qw_q * qw_q;
      pxz_q <= qx_q * qz_q;
      pwy_q <= qw_q * qy_q;
      pxy_q <= qx_q * qy_q;
      pwz_q <= qw_q * qz_q;
    end
    if (state_q == S_Y2) begin
      n_q  <= (QW+2)'(pxx_q) + (QW+2)'(pyy_q) + (QW+2)'(pzz_q) + (QW+2)'(pww_q);
      t_q  <= (QW+1)'(pxz_q) - (QW+1)'(pwy_q);
      ya_q <= ((QW+2)'(pxy_q) + (QW+2)'(pwz_q)) <<< 1;
      yb_q <= (QW+1)'(pww_q) + (QW+1)'(pxx_q) - (QW+1)'(pyy_q) - (QW+1)'(pzz_q);
    end
    if (state_q == S_Y3) begin
      // near gimbal lock the yaw comes from x and y alone
      if (n_q > 0 && t_pos >= n_k) begin
        mode_q <= YawFlipNeg;
      end else if (n_q > 0 && t_neg >= n_k) begin
        mode_q <= YawFlipPos;
      end else begin
        mode_q <= YawNormal;
      end
    end
  end

  // ---------------------------------------------------------------- shared CORDIC
  assign at_start = (state_q == S_BSTART) || (state_q == S_YSTART);

  always_comb begin
    if (state_q == S_BSTART) begin
      at_x = CordW'(best_dx_q);
      at_y = CordW'(best_dy_q);
    end else if (mode_q == YawNormal) begin
      at_x = CordW'(yb_q);
      at_y = CordW'(ya_q);
    end else begin
      at_x = CordW'(qx_q);
      at_y = CordW'(qy_q);
    end
  end

  nwhc_atan #(
    .ITERS(CORDIC_ITERATIONS)
  ) u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(at_start),
    .y_i    (at_y),
    .x_i    (at_x),
    .done_o (at_done),
    .turn_o (at_turn)
  );

  always_comb begin
    case (mode_q)
      YawFlipNeg: yaw_d = TurnW'(0) - (at_turn << 1);
      YawFlipPos: yaw_d = at_turn << 1;
      default:    yaw_d = at_turn;
    endcase
  end

  // ---------------------------------------------------------------- error and gain
  assign err_rnd = bear_q - yaw_q + TurnW'(32'h8000);
  assign e_val   = $signed(err_rnd[TurnW-1:TurnW-AngOutW]);

  assign p_mag = p2_q[57] ? 58'(-p2_q) : 58'(p2_q);
  assign p_rnd = p_mag + (58'(1) << 39);
  assign pm    = p_rnd[57:40];

  always_comb begin
    if (p2_q[57]) begin
      ang_d = (pm > 18'd32768) ? -16'sd32768 : AngOutW'(-$signed({1'b0, pm}));
    end else begin
      ang_d = (pm > 18'd32767) ? 16'sd32767 : AngOutW'(pm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_BWAIT && at_done) bear_q <= at_turn;
    if (state_q == S_YWAIT && at_done) yaw_q  <= yaw_d;
    if (state_q == S_E1) p1_q <= $signed({1'b0, gain_q}) * e_val;
    if (state_q == S_E2) p2_q <= p1_q * MradQ16;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && op_i == OpQuery) begin
          state_d = (count_q == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN:   if (scan_done) state_d = S_BSTART;
      S_BSTART: state_d = S_BWAIT;
      S_BWAIT:  if (at_done) state_d = S_Y1;
      S_Y1:     state_d = S_Y2;
      S_Y2:     state_d = S_Y3;
      S_Y3:     state_d = S_YSTART;
      S_YSTART: state_d = S_YWAIT;
      S_YWAIT:  if (at_done) state_d = S_E1;
      S_E1:     state_d = S_E2;
      S_E2:     state_d = S_FIN;
      S_FIN:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- result register
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (empty_q) begin
        lin_q     <= '0;
        ang_q     <= '0;
        empty_o_q <= 1'b1;
        nidx_q    <= '0;
      end else begin
        lin_q     <= speed_q;
        ang_q     <= ang_d;
        empty_o_q <= 1'b0;
        nidx_q    <= IdxOutW'(best_i_q);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;
  assign plan_empty_o    = empty_o_q;
  assign nearest_index_o = nidx_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nwhc_pkg::*;

  // one input transfer as the sequence builder sees it
  typedef struct {
    logic [1:0]         op;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_cmd_t;

  // one steering command the block should hand back
  typedef struct {
    logic signed [11:0] lin;
    logic signed [15:0] ang;
    logic               empty;
    logic [9:0]         idx;
  } steer_t;

  localparam int StallLimit = 20000;
  localparam int Waypoints  = 1024;
  localparam int CordSteps  = 16;

  // atan(2^-i) in 2^-32 turn
  localparam logic [31:0] AtanStep [CordSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [GainW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = OpAppend;
  logic signed [PosW-1:0] pos_x_i = '0, pos_y_i = '0;
  logic signed [QuatW-1:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SpeedW-1:0] linear_speed_o;
  logic signed [AngOutW-1:0] angular_speed_o;
  logic plan_empty_o;
  logic [IdxOutW-1:0] nearest_index_o;

  always #5 clk_i = ~clk_i;

  nearest_waypoint_heading_controller u_dut (.*);

  // predictor state: its own copy of the plan and the registers
  logic signed [23:0] plan_x [Waypoints];
  logic signed [23:0] plan_y [Waypoints];
  int unsigned        plan_len = 0;
  logic [11:0]        gain_reg = 12'd384;
  logic [11:0]        speed_reg = 12'd200;

  pose_cmd_t pending_cmds [$];
  steer_t    expected_steer [$];
  bit        failed = 1'b0;
  bit        no_idle = 1'b0;
  int        quiet_cycles = 0;

  // vectoring CORDIC, angle in 2^-32 turn
  function automatic logic [31:0] bearing_turns(longint y, longint x);
    logic [31:0] z;
    longint m, xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    m = (x > (y < 0 ? -y : y)) ? x : (y < 0 ? -y : y);
    while (m < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < CordSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanStep[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanStep[i];
      end
    end
    return z;
  endfunction

  function automatic logic [31:0] yaw_from_quat(longint qx, longint qy, longint qz,
                                                longint qw);
    longint n, t;
    n = qx * qx + qy * qy + qz * qz + qw * qw;
    t = qx * qz - qw * qy;
    if (n > 0) begin
      // gimbal lock near pitch -pi/2 and +pi/2
      if (200000 * t >= 99999 * n) return 32'd0 - 2 * bearing_turns(qy, qx);
      if (-200000 * t >= 99999 * n) return 2 * bearing_turns(qy, qx);
    end
    return bearing_turns(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
  endfunction

  // applies one accepted command to the plan; queries give a steering command
  function automatic bit steer_step(pose_cmd_t c, output steer_t s);
    int unsigned best;
    longint ax, ay, dx, dy, prod, r, pm;
    longint unsigned d, best_d;
    logic [31:0] err, rnd;
    logic signed [15:0] e;
    best = 0;
    best_d = 0;
    s = '{lin: '0, ang: '0, empty: 1'b0, idx: '0};
    case (c.op)
      OpAppend: begin
        if (plan_len < Waypoints) begin
          plan_x[plan_len] = c.px;
          plan_y[plan_len] = c.py;
          plan_len++;
        end
        return 1'b0;
      end
      OpClear: begin
        plan_len = 0;
        return 1'b0;
      end
      OpQuery: ;
      default: return 1'b0;
    endcase
    if (plan_len == 0) begin
      s.empty = 1'b1;
      return 1'b1;
    end
    for (int unsigned i = 0; i < plan_len; i++) begin
      ax = longint'(plan_x[i]) - longint'(c.px);
      ay = longint'(plan_y[i]) - longint'(c.py);
      d = ax * ax + ay * ay;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    dx = longint'(plan_x[best]) - longint'(c.px);
    dy = longint'(plan_y[best]) - longint'(c.py);
    err = bearing_turns(dy, dx) - yaw_from_quat(c.qx, c.qy, c.qz, c.qw);
    rnd = err + 32'h8000;
    e = rnd[31:16];
    prod = longint'(gain_reg) * longint'(e) * 64'sd411774832;
    pm = ((prod < 0 ? -prod : prod) + (64'sd1 <<< 39)) >>> 40;
    r = prod < 0 ? -pm : pm;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    s.lin = speed_reg;
    s.ang = r[15:0];
    s.idx = best[9:0];
    return 1'b1;
  endfunction

  // driver: next command when the channel is free, with random gaps unless no_idle is set
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
        pose_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        op_i <= c.op;
        pos_x_i <= c.px;
        pos_y_i <= c.py;
        quat_x_i <= c.qx;
        quat_y_i <= c.qy;
        quat_z_i <= c.qz;
        quat_w_i <= c.qw;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && (no_idle || $urandom_range(99) >= 34);
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk_i) begin
    pose_cmd_t c;
    steer_t s, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        c = '{op_i, pos_x_i, pos_y_i, quat_x_i, quat_y_i, quat_z_i, quat_w_i};
        if (steer_step(c, s)) expected_steer.push_back(s);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_steer.size() == 0) begin
          $error("unexpected result transfer");
          failed = 1'b1;
        end else begin
          want = expected_steer.pop_front();
          if (linear_speed_o !== want.lin) begin
            $error("linear_speed exp %0d got %0d", want.lin, linear_speed_o);
            failed = 1'b1;
          end
          if (angular_speed_o !== want.ang) begin
            $error("angular_speed exp %0d got %0d", want.ang, angular_speed_o);
            failed = 1'b1;
          end
          if (plan_empty_o !== want.empty) begin
            $error("plan_empty exp %0d got %0d", want.empty, plan_empty_o);
            failed = 1'b1;
          end
          if (nearest_index_o !== want.idx) begin
            $error("nearest_index exp %0d got %0d", want.idx, nearest_index_o);
            failed = 1'b1;
          end
        end
      end
      // watchdog on stalled traffic
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet_cycles <= 0;
      else if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pose_cmd_t mk(logic [1:0] op, int px, int py, int qx = 0,
                                   int qy = 0, int qz = 0, int qw = 32767);
    pose_cmd_t c;
    c = '{op, px[23:0], py[23:0], qx[15:0], qy[15:0], qz[15:0], qw[15:0]};
    return c;
  endfunction

  // mix of tight clusters (ties, close calls) and the full 24-bit span
  function automatic int rand_pos();
    case ($urandom_range(3))
      0: return $signed($urandom()) >>> 8;
      1: return int'($urandom_range(40)) - 20;
      default: return int'($urandom_range(8000)) - 4000;
    endcase
  endfunction

  function automatic pose_cmd_t rand_query();
    pose_cmd_t c;
    c = mk(OpQuery, rand_pos(), rand_pos(), $urandom(), $urandom(), $urandom(), $urandom());
    case ($urandom_range(9))
      0: begin c.qx = 0; c.qz = 0; c.qy = 16'sd23170; c.qw = 16'sd23170; end
      1: begin c.qx = 16'sd23170; c.qz = 16'sd23170; c.qy = 0; c.qw = 0; end
      2: begin c.qx = 0; c.qy = 0; c.qz = 0; c.qw = 0; end
      default: ;
    endcase
    return c;
  endfunction

  // waits until all traffic has settled, then writes one register
  task automatic write_reg(logic idx, logic [11:0] val);
    while (pending_cmds.size() > 0 || expected_steer.size() > 0 || in_valid_i)
      @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgTurnGain) gain_reg = val;
    else speed_reg = val;
  endtask

  logic [11:0] gains [8] = '{12'd0, 12'd4095, 12'd384, 12'd1, 12'd256, 12'd4095, 12'd77, 12'd2000};
  logic [11:0] speeds [8] = '{-12'sd2000, 12'sd2000, 12'sd0, 12'sd2047, -12'sd2048, 12'sd200,
                              -12'sd1, 12'sd1234};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty plan, dead op, on-waypoint, tie, extremes, gimbal lock
    pending_cmds.push_back(mk(OpQuery, 0, 0));
    pending_cmds.push_back(mk(2'd3, 5, 5));
    pending_cmds.push_back(mk(OpAppend, 100, 100));
    pending_cmds.push_back(mk(OpQuery, 100, 100));
    pending_cmds.push_back(mk(OpAppend, -100, 100));
    pending_cmds.push_back(mk(OpQuery, 0, 0, 0, 0, 0, -32768));
    pending_cmds.push_back(mk(OpQuery, 0, 50, 0, 23170, 0, 23170));
    pending_cmds.push_back(mk(OpQuery, 0, -50, 23170, 0, 23170, 0));
    pending_cmds.push_back(mk(OpAppend, 8388607, -8388608));
    pending_cmds.push_back(mk(OpAppend, -8388608, 8388607));
    pending_cmds.push_back(mk(OpQuery, -8388608, -8388608, 32767, 32767, 32767, 32767));
    pending_cmds.push_back(mk(OpQuery, 8388607, 8388607, -32768, -32768, -32768, -32768));
    pending_cmds.push_back(mk(OpQuery, 200, 100, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OpQuery, -200, 100, 0, 0, 32767, 0));
    pending_cmds.push_back(mk(OpClear, 0, 0));
    pending_cmds.push_back(mk(OpQuery, 1, 1));

    // phases through register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgTurnGain, gains[ph]);
      write_reg(CfgFwdSpeed, speeds[ph]);
      no_idle = (ph == 3);
      for (int seq = 0; seq < 6; seq++) begin
        if ($urandom_range(9) < 8) pending_cmds.push_back(mk(OpClear, 0, 0));
        repeat ($urandom_range(12)) pending_cmds.push_back(mk(OpAppend, rand_pos(), rand_pos()));
        repeat ($urandom_range(1, 4)) pending_cmds.push_back(rand_query());
        if ($urandom_range(5) == 0) pending_cmds.push_back(mk(2'd3, rand_pos(), rand_pos()));
      end
    end
    no_idle = 1'b0;

    // a longer plan for a longer scan
    pending_cmds.push_back(mk(OpClear, 0, 0));
    for (int i = 0; i < 64; i++)
      pending_cmds.push_back(mk(OpAppend, int'($urandom_range(4000)) - 2000,
                                int'($urandom_range(4000)) - 2000));
    repeat (4) pending_cmds.push_back(rand_query());

    while (pending_cmds.size() > 0 || expected_steer.size() > 0 || in_valid_i)
      @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed && expected_steer.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> nearest_waypoint_heading_controller.f
rtl/nwhc_pkg.sv
rtl/nwhc_cordic_cell.sv
rtl/nwhc_atan.sv
rtl/nearest_waypoint_heading_controller.sv
sim/testbench.sv
